### src/psu_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the png scanline unfilter
package psu_pkg;

  localparam int MAX_LINE_BYTES  = 65536;
  localparam int MAX_PIXEL_BYTES = 8;

  localparam int LINE_ADDR_W = $clog2(MAX_LINE_BYTES);
  localparam int LINE_LEN_W  = LINE_ADDR_W + 1;
  localparam int WIN_IDX_W   = $clog2(MAX_PIXEL_BYTES);
  localparam int BPP_W       = 4;
  localparam int CFG_DATA_W  = 17;
  localparam int CFG_IDX_W   = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINE_BYTES      = 1'b0,
    CFG_BYTES_PER_PIXEL = 1'b1
  } cfg_reg_t;

  localparam logic [7:0] FILT_SUB   = 8'd1;
  localparam logic [7:0] FILT_UP    = 8'd2;
  localparam logic [7:0] FILT_AVG   = 8'd3;
  localparam logic [7:0] FILT_PAETH = 8'd4;

  // left, up and upper-left taps of one byte
  typedef struct packed {
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
  } taps_t;

endpackage

### src/psu_line_store.sv
`timescale 1ns / 1ps
// previous-row byte store, one write and one registered read per cycle
module psu_line_store (
  input  logic                           clk,
  input  logic                           we,
  input  logic [psu_pkg::LINE_ADDR_W-1:0] waddr,
  input  logic [7:0]                     wdata,
  input  logic                           re,
  input  logic [psu_pkg::LINE_ADDR_W-1:0] raddr,
  output logic [7:0]                     rdata
);
  import psu_pkg::*;

  logic [7:0] mem [MAX_LINE_BYTES];

  // read returns the old contents on an address collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/psu_predictor.sv
`timescale 1ns / 1ps
// filter reconstruction of one byte: sub, up, average and paeth
module psu_predictor (
  input  logic [7:0]     filtered_byte,
  input  logic [7:0]     filter_code,
  input  psu_pkg::taps_t taps,
  output logic [7:0]     recon_byte
);
  import psu_pkg::*;

  logic signed [9:0] a_s, b_s, c_s;
  logic signed [9:0] d_bc, d_ac, d_abc;
  logic [9:0]        pa, pb, pc;
  logic [7:0]        paeth;
  logic [8:0]        avg_sum;
  logic [7:0]        pred;

  always_comb begin
    a_s   = signed'({2'b00, taps.a});
    b_s   = signed'({2'b00, taps.b});
    c_s   = signed'({2'b00, taps.c});
    // |p-a| = |b-c|, |p-b| = |a-c|, |p-c| = |a+b-2c|
    d_bc  = b_s - c_s;
    d_ac  = a_s - c_s;
    d_abc = d_bc + d_ac;
    pa    = d_bc[9]  ? 10'(-d_bc)  : 10'(d_bc);
    pb    = d_ac[9]  ? 10'(-d_ac)  : 10'(d_ac);
    pc    = d_abc[9] ? 10'(-d_abc) : 10'(d_abc);
    if (pa <= pb && pa <= pc) begin
      paeth = taps.a;
    end else if (pb <= pc) begin
      paeth = taps.b;
    end else begin
      paeth = taps.c;
    end

    avg_sum = {1'b0, taps.a} + {1'b0, taps.b};

    case (filter_code)
      FILT_SUB:   pred = taps.a;
      FILT_UP:    pred = taps.b;
      FILT_AVG:   pred = avg_sum[8:1];
      FILT_PAETH: pred = paeth;
      default:    pred = 8'd0;
    endcase

    recon_byte = filtered_byte + pred;
  end

endmodule

### src/png_scanline_unfilter.sv
`timescale 1ns / 1ps
// Top level of the png scanline unfilter. One filtered byte enters per cycle
// and one reconstructed byte leaves per cycle while m_tready is high; an accepted
// word passes stage one, then the output register. The previous-row store is
// read when the byte is taken, so its registered data lines up with stage one,
// and the byte just ahead is bypassed in when both hit one column.
// The store holds 65536 bytes and needs no clearing after reset: up taps are
// forced to zero on the first row of a pass. line_bytes (register 0) and
// bytes_per_pixel (register 1) are clamped to 1..65536 and 1..8 when written
// and should be changed only while no word is in flight.
module png_scanline_unfilter (
  input  logic                           clk,
  input  logic                           rst,
  // configuration
  input  logic                           cfg_we,
  input  logic [psu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [psu_pkg::CFG_DATA_W-1:0] cfg_data,
  // filtered bytes in
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,   // filtered_byte
  input  logic [8:0]                     s_tuser,   // filter_code[7:0], pass_start[8]
  // reconstructed bytes out
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [7:0]                     m_tdata,   // recon_byte
  output logic                           m_tlast    // row_end
);
  import psu_pkg::*;

  // configuration, held clamped
  logic [LINE_LEN_W-1:0] line_bytes;
  logic [BPP_W-1:0]      bytes_per_pixel;

  // column tracking
  logic [LINE_ADDR_W-1:0] column_index;
  logic                   prior_row_valid;

  // stage one registers
  logic                   s1_valid;
  logic [7:0]             s1_byte;
  logic [7:0]             s1_code;
  logic [LINE_ADDR_W-1:0] s1_col;
  logic                   s1_pv;
  logic                   s1_left_ok;
  logic                   s1_last;
  logic                   fwd;
  logic [7:0]             fwd_data;

  // pixel windows
  logic [7:0] left_window [MAX_PIXEL_BYTES];
  logic [7:0] upper_left_window [MAX_PIXEL_BYTES];

  logic                   accept;
  logic                   s1_adv;
  logic                   pass_start;
  logic [LINE_ADDR_W-1:0] col_c;
  logic                   last_c;
  logic                   left_ok_c;
  logic [LINE_LEN_W-1:0]  col_plus;
  logic [WIN_IDX_W-1:0]   win_idx;
  logic [7:0]             rd_data;
  logic [7:0]             b_raw;
  taps_t                  taps;
  logic [7:0]             recon;

  assign pass_start = s_tuser[8];
  assign s1_adv     = s1_valid && (!m_tvalid || m_tready);
  assign s_tready   = !s1_valid || s1_adv;
  assign accept     = s_tvalid && s_tready;

  always_comb begin
    if (pass_start || ({1'b0, column_index} >= line_bytes)) begin
      col_c = '0;
    end else begin
      col_c = column_index;
    end
    col_plus  = {1'b0, col_c} + LINE_LEN_W'(1);
    last_c    = (col_plus == line_bytes);
    left_ok_c = (col_c >= LINE_ADDR_W'(bytes_per_pixel));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_bytes      <= LINE_LEN_W'(1);
      bytes_per_pixel <= BPP_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LINE_BYTES: begin
          if (cfg_data == '0) begin
            line_bytes <= LINE_LEN_W'(1);
          end else if (cfg_data > CFG_DATA_W'(MAX_LINE_BYTES)) begin
            line_bytes <= LINE_LEN_W'(MAX_LINE_BYTES);
          end else begin
            line_bytes <= LINE_LEN_W'(cfg_data);
          end
        end
        CFG_BYTES_PER_PIXEL: begin
          if (cfg_data[BPP_W-1:0] == '0) begin
            bytes_per_pixel <= BPP_W'(1);
          end else if (cfg_data[BPP_W-1:0] > BPP_W'(MAX_PIXEL_BYTES)) begin
            bytes_per_pixel <= BPP_W'(MAX_PIXEL_BYTES);
          end else begin
            bytes_per_pixel <= cfg_data[BPP_W-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_index    <= '0;
      prior_row_valid <= 1'b0;
      s1_valid        <= 1'b0;
      fwd             <= 1'b0;
    end else begin
      if (accept) begin
        column_index    <= last_c ? '0 : col_plus[LINE_ADDR_W-1:0];
        prior_row_valid <= last_c || (prior_row_valid && !pass_start);
        s1_valid        <= 1'b1;
        // up tap written by the word leaving stage one this very edge
        fwd             <= s1_adv && (s1_col == col_c);
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_byte    <= s_tdata;
      s1_code    <= s_tuser[7:0];
      s1_col     <= col_c;
      s1_pv      <= prior_row_valid && !pass_start;
      s1_left_ok <= left_ok_c;
      s1_last    <= last_c;
      fwd_data   <= recon;
    end
  end

  psu_line_store u_store (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col),
    .wdata (recon),
    .re    (accept),
    .raddr (col_c),
    .rdata (rd_data)
  );

  always_comb begin
    win_idx = WIN_IDX_W'(bytes_per_pixel - BPP_W'(1));
    b_raw   = fwd ? fwd_data : rd_data;
    taps.a  = s1_left_ok ? left_window[win_idx] : 8'd0;
    taps.b  = s1_pv ? b_raw : 8'd0;
    taps.c  = (s1_pv && s1_left_ok) ? upper_left_window[win_idx] : 8'd0;
  end

  psu_predictor u_pred (
    .filtered_byte (s1_byte),
    .filter_code   (s1_code),
    .taps          (taps),
    .recon_byte    (recon)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
        left_window[i]       <= 8'd0;
        upper_left_window[i] <= 8'd0;
      end
    end else if (s1_adv) begin
      for (int i = MAX_PIXEL_BYTES - 1; i > 0; i--) begin
        left_window[i]       <= left_window[i-1];
        upper_left_window[i] <= upper_left_window[i-1];
      end
      left_window[0]       <= recon;
      upper_left_window[0] <= taps.b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      m_tdata <= recon;
      m_tlast <= s1_last;
    end
  end

  // a row-ending word sends the column back to zero
  a_col_wrap: assert property (@(posedge clk) disable iff (rst)
    accept && last_c |=> column_index == '0)
    else $error("column did not wrap after row end");

  // the prior row only becomes valid through a completed row
  a_pv_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(prior_row_valid) |-> $past(accept && last_c))
    else $error("prior row valid without a finished row");

  // a pass start never sees up taps
  a_pass_up: assert property (@(posedge clk) disable iff (rst)
    accept && pass_start |=> !s1_pv)
    else $error("up taps enabled on first row of a pass");

  // an output word only appears after stage one hands one over
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s1_adv))
    else $error("output word without a stage one word");

endmodule
